// File: rtl/pfbw_pkg.sv
// ----------------------------------------------------------------------------
// Paged framebuffer pixel writer package
// Shared types and constants: word structs for both channels, operation
// codes and default display geometry.
// ----------------------------------------------------------------------------
package pfbw_pkg;

	// Default display geometry.
	localparam int DISP_WIDTH_DEF   = 128;
	localparam int DISP_HEIGHT_DEF  = 64;
	localparam int CHIP_COLUMNS_DEF = 64;

	// Rows held by one page byte, and the single-row bit pattern.
	localparam int         PAGE_ROWS = 8;
	localparam logic [7:0] ROW_BIT   = 8'h01;

	// Operation codes carried in the kind field. The fourth code is unused.
	typedef enum logic [1:0] {
		KIND_DOT  = 2'd0,
		KIND_BYTE = 2'd1,
		KIND_FILL = 2'd2
	} pfbw_kind_t;

	// Input word: one drawing operation.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] column;
		logic [7:0] row;
		logic       paint;
		logic [7:0] byte_value;
		logic [7:0] rect_top;
		logic [7:0] rect_end;
	} pfbw_in_t;

	// Output word: one byte written to the display controller.
	typedef struct packed {
		logic       chip_select;
		logic [5:0] column_address;
		logic [2:0] page_address;
		logic [7:0] write_data;
	} pfbw_out_t;

endpackage

// File: rtl/pfbw_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read; a read of the
// address being written returns the old contents.
// ----------------------------------------------------------------------------
module pfbw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// File: rtl/paged_framebuffer_pixel_writer_top.sv
// ----------------------------------------------------------------------------
// Paged framebuffer pixel writer
// Keeps a shadow copy of a page-organized monochrome display and turns each
// drawing operation into the byte written to one controller chip.
//
//   channel  direction  handshake            word
//   in       input      in_valid/in_ready    in_data  (pfbw_in_t)
//   out      output     out_valid/out_ready  out_data (pfbw_out_t)
//
// One word is accepted per cycle while the output is not stalled; its result
// passes the read stage, which the shadow RAM's registered read fills, and
// the modify, write-back and output register share the edge that ends it.
// Back-to-back hits on one byte are forwarded.
// After reset a clearing pass writes zero to every shadow entry, one per
// cycle (DISP_WIDTH * ceil(DISP_HEIGHT / 8) entries, 1024 by default);
// in_ready stays low until it ends. A stalled output holds the read stage.
// Out-of-range or unused operations are accepted and produce nothing.
// ----------------------------------------------------------------------------
module paged_framebuffer_pixel_writer_top #(
	parameter int DISP_WIDTH   = pfbw_pkg::DISP_WIDTH_DEF,
	parameter int DISP_HEIGHT  = pfbw_pkg::DISP_HEIGHT_DEF,
	parameter int CHIP_COLUMNS = pfbw_pkg::CHIP_COLUMNS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pfbw_pkg::pfbw_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output pfbw_pkg::pfbw_out_t out_data
);

	import pfbw_pkg::*;

	localparam int PAGES = (DISP_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
	localparam int DEPTH = DISP_WIDTH * PAGES;
	localparam int AW    = $clog2(DEPTH);

	// Clamp a rectangle edge to a bit position within the page at base.
	function automatic logic [3:0] clamp_bit(input logic [7:0] v, input logic [7:0] base);
		logic [7:0] diff;
		diff = v - base;
		if (v <= base) begin
			return 4'd0;
		end else if (diff >= 8'(PAGE_ROWS)) begin
			return 4'(PAGE_ROWS);
		end else begin
			return diff[3:0];
		end
	endfunction

	// Chip and column-address lookup over every possible column value.
	logic       chip_lut [256];
	logic [5:0] coladdr_lut [256];

	for (genvar g = 0; g < 256; g++) begin : g_col_lut
		assign chip_lut[g]    = 1'(g / CHIP_COLUMNS);
		assign coladdr_lut[g] = 6'(g % CHIP_COLUMNS);
	end

	// Pipeline and control registers.
	logic            v_s1;
	logic [AW-1:0]   addr_s1;
	logic            replace_s1;
	logic            on_s1;
	logic [7:0]      mask_s1;
	logic [7:0]      byte_s1;
	logic            chip_s1;
	logic [5:0]      coladdr_s1;
	logic [2:0]      page_s1;

	logic            out_valid_q;
	pfbw_out_t       out_q;
	logic            fwd_v_q;
	logic [AW-1:0]   fwd_addr_q;
	logic [7:0]      fwd_data_q;
	logic            clr_busy_q;
	logic [AW-1:0]   clr_addr_q;

	// Decode of the incoming word.
	logic            in_fire;
	logic            in_ok;
	logic [15:0]     idx_full;
	logic [AW-1:0]   in_addr;
	logic [7:0]      page_base;
	logic [3:0]      fill_first;
	logic [3:0]      fill_end;
	logic [7:0]      in_mask;

	assign in_fire   = in_valid && in_ready;
	assign idx_full  = 16'(in_data.column) * 16'(PAGES) + 16'(in_data.row[7:3]);
	assign in_addr   = idx_full[AW-1:0];
	assign page_base = {in_data.row[7:3], 3'b000};
	assign fill_first = clamp_bit(in_data.rect_top, page_base);
	assign fill_end   = clamp_bit(in_data.rect_end, page_base);

	always_comb begin
		in_ok = ({1'b0, in_data.column} < 9'(DISP_WIDTH))
			&& ({1'b0, in_data.row} < 9'(DISP_HEIGHT))
			&& (in_data.kind inside {KIND_DOT, KIND_BYTE, KIND_FILL});
	end

	// Row mask: one bit for a dot, a span of rows for a fill.
	always_comb begin
		in_mask = '0;
		if (in_data.kind == KIND_DOT) begin
			in_mask = ROW_BIT << in_data.row[2:0];
		end else begin
			for (int i = 0; i < PAGE_ROWS; i++) begin
				in_mask[i] = (4'(i) >= fill_first) && (4'(i) < fill_end);
			end
		end
	end

	// Handshake: the read stage advances when the output register is free.
	logic adv;
	logic fire_s1;

	assign adv      = !out_valid_q || out_ready;
	assign fire_s1  = v_s1 && adv;
	assign in_ready = !clr_busy_q && (!v_s1 || adv);

	// Read stage: register the decoded operation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire) begin
			v_s1 <= in_ok;
		end else if (fire_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && in_ok) begin
			addr_s1    <= in_addr;
			replace_s1 <= (in_data.kind == KIND_BYTE);
			on_s1      <= in_data.paint;
			mask_s1    <= in_mask;
			byte_s1    <= in_data.byte_value;
			chip_s1    <= chip_lut[in_data.column];
			coladdr_s1 <= coladdr_lut[in_data.column];
			page_s1    <= in_data.row[5:3];
		end
	end

	// Shadow store. A stalled item re-reads its own address every cycle.
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [7:0]      ram_wdata;
	logic [AW-1:0]   ram_raddr;
	logic [7:0]      ram_rdata;

	assign ram_raddr = in_fire ? in_addr : addr_s1;

	pfbw_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_shadow (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// Modify stage: forward the last write when it hit the same byte.
	logic [7:0] old_byte;
	logic [7:0] new_byte;

	always_comb begin
		old_byte = (fwd_v_q && fwd_addr_q == addr_s1) ? fwd_data_q : ram_rdata;
		if (replace_s1) begin
			new_byte = byte_s1;
		end else if (on_s1) begin
			new_byte = old_byte | mask_s1;
		end else begin
			new_byte = old_byte & ~mask_s1;
		end
	end

	// Write port: clearing pass first, then write-back of each item.
	always_comb begin
		if (clr_busy_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = fire_s1;
			ram_waddr = addr_s1;
			ram_wdata = new_byte;
		end
	end

	// Clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Forwarding register for the most recent write-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else if (fire_s1) begin
			fwd_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= new_byte;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_q.chip_select    <= chip_s1;
			out_q.column_address <= coladdr_s1;
			out_q.page_address   <= page_s1;
			out_q.write_data     <= new_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	// No word is taken while the store is being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !in_ready)
		else $error("input accepted during clearing pass");

	// A stalled read stage keeps its item and address.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(addr_s1)))
		else $error("read stage lost its item while stalled");

	// The forwarding register always matches the word just emitted.
	a_fwd_matches_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> (out_valid_q && fwd_v_q && fwd_data_q == out_q.write_data))
		else $error("forwarded byte differs from emitted byte");

	// An item never overwrites a pending result.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !fire_s1)
		else $error("pending result overwritten");
`endif

endmodule

// File: tb/pfbw_write_checker.sv
// ----------------------------------------------------------------------------
// Paged framebuffer write checker
// Watches both channels of the pixel writer. It keeps its own shadow copy of
// the display pages, works out the controller write that each accepted
// drawing word causes, and compares every output word with the oldest
// pending write, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pfbw_write_checker #(
	parameter int DISP_WIDTH   = pfbw_pkg::DISP_WIDTH_DEF,
	parameter int DISP_HEIGHT  = pfbw_pkg::DISP_HEIGHT_DEF,
	parameter int CHIP_COLUMNS = pfbw_pkg::CHIP_COLUMNS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  pfbw_pkg::pfbw_in_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  pfbw_pkg::pfbw_out_t out_data,
	output int                  fail_count,
	output int                  pending_writes,
	output int                  checked_writes,
	output int                  ignored_ops
);

	import pfbw_pkg::*;

	localparam int PAGES_PER_COLUMN = (DISP_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
	localparam int SHADOW_DEPTH     = DISP_WIDTH * PAGES_PER_COLUMN;

	logic [7:0] shadow_bytes [SHADOW_DEPTH];
	pfbw_out_t  expected_writes [$];

	// Bit position of a rectangle edge within the page starting at base row.
	function automatic int page_edge(input logic [7:0] edge_row, input int base);
		if (int'(edge_row) <= base)
			return 0;
		if (int'(edge_row) - base >= PAGE_ROWS)
			return PAGE_ROWS;
		return int'(edge_row) - base;
	endfunction

	// Applies one drawing word to the shadow pages. Returns 1 with the
	// controller write it causes, or 0 when the word is ignored.
	function automatic logic apply_draw_op(input pfbw_in_t op, output pfbw_out_t wr);
		int         page;
		int         slot;
		int         first;
		int         stop;
		logic [7:0] cur;
		logic [7:0] mask;
		wr = '0;
		if (int'(op.column) >= DISP_WIDTH || int'(op.row) >= DISP_HEIGHT)
			return 1'b0;
		page = int'(op.row) / PAGE_ROWS;
		slot = int'(op.column) * PAGES_PER_COLUMN + page;
		cur  = shadow_bytes[slot];
		case (op.kind)
			KIND_DOT: begin
				mask = ROW_BIT << (int'(op.row) % PAGE_ROWS);
				cur  = op.paint ? (cur | mask) : (cur & ~mask);
			end
			KIND_BYTE: begin
				cur = op.byte_value;
			end
			KIND_FILL: begin
				first = page_edge(op.rect_top, page * PAGE_ROWS);
				stop  = page_edge(op.rect_end, page * PAGE_ROWS);
				mask  = '0;
				for (int b = 0; b < PAGE_ROWS; b++)
					mask[b] = (b >= first) && (b < stop);
				cur = op.paint ? (cur | mask) : (cur & ~mask);
			end
			default: begin
				return 1'b0;
			end
		endcase
		shadow_bytes[slot] = cur;
		wr.chip_select     = 1'(int'(op.column) / CHIP_COLUMNS);
		wr.column_address  = 6'(int'(op.column) % CHIP_COLUMNS);
		wr.page_address    = 3'(page);
		wr.write_data      = cur;
		return 1'b1;
	endfunction

	// Output words are checked before the input word of the same edge is
	// predicted; the pipeline latency keeps the two apart anyway.
	always @(posedge clk or negedge arst_n) begin
		pfbw_out_t exp_wr;
		pfbw_out_t new_wr;
		if (!arst_n) begin
			foreach (shadow_bytes[i])
				shadow_bytes[i] = '0;
			expected_writes.delete();
			fail_count     = 0;
			checked_writes = 0;
			ignored_ops    = 0;
			pending_writes = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_writes.size() == 0) begin
					$error("unexpected output word: chip %0d column %0d page %0d data %02h",
						out_data.chip_select, out_data.column_address,
						out_data.page_address, out_data.write_data);
					fail_count++;
				end else begin
					exp_wr = expected_writes.pop_front();
					checked_writes++;
					if (out_data.chip_select !== exp_wr.chip_select) begin
						$error("chip_select: expected %0d, got %0d",
							exp_wr.chip_select, out_data.chip_select);
						fail_count++;
					end
					if (out_data.column_address !== exp_wr.column_address) begin
						$error("column_address: expected %0d, got %0d",
							exp_wr.column_address, out_data.column_address);
						fail_count++;
					end
					if (out_data.page_address !== exp_wr.page_address) begin
						$error("page_address: expected %0d, got %0d",
							exp_wr.page_address, out_data.page_address);
						fail_count++;
					end
					if (out_data.write_data !== exp_wr.write_data) begin
						$error("write_data: expected %02h, got %02h",
							exp_wr.write_data, out_data.write_data);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (apply_draw_op(in_data, new_wr))
					expected_writes.push_back(new_wr);
				else
					ignored_ops++;
			end
			pending_writes = expected_writes.size();
		end
	end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Paged framebuffer pixel writer testbench
// Drives directed and random drawing words into the pixel writer with random
// idle bursts on both channels, while a separate checker predicts and checks
// every controller write. The top only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import pfbw_pkg::*;

	localparam logic [1:0] KIND_UNUSED  = 2'd3;
	localparam int         RANDOM_OPS   = 400;
	localparam int         CALM_OPS     = 60;
	localparam int         STALL_LIMIT  = 4000;
	localparam int         DRAIN_CYCLES = 8;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	pfbw_in_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	pfbw_out_t out_data;

	int   fail_count;
	int   pending_writes;
	int   checked_writes;
	int   ignored_ops;
	int   quiet_cycles = 0;
	logic calm         = 1'b0;
	int   kind_count [4] = '{0, 0, 0, 0};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	paged_framebuffer_pixel_writer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	pfbw_write_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.fail_count     (fail_count),
		.pending_writes (pending_writes),
		.checked_writes (checked_writes),
		.ignored_ops    (ignored_ops)
	);

	// Watchdog: ends the run when no word moves on either channel for too
	// long. The limit covers the clearing pass after reset.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Output side: long stretches of ready, broken by random stalls
	// until the calm part at the end of the run.
	initial begin
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (!calm && $urandom_range(0, 2) != 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	function automatic pfbw_in_t make_op(input logic [1:0] kind, input logic [7:0] column,
		input logic [7:0] row, input logic paint, input logic [7:0] byte_value,
		input logic [7:0] rect_top, input logic [7:0] rect_end);
		pfbw_in_t op;
		op.kind       = kind;
		op.column     = column;
		op.row        = row;
		op.paint      = paint;
		op.byte_value = byte_value;
		op.rect_top   = rect_top;
		op.rect_end   = rect_end;
		return op;
	endfunction

	// Presents one word and holds it until accepted. The handshake is sampled
	// at the falling edge, so the word moves at the following rising edge.
	// Afterwards an idle burst may follow.
	task automatic send_op(input pfbw_in_t op);
		in_valid <= 1'b1;
		in_data  <= op;
		do
			@(negedge clk);
		while (!in_ready);
		@(posedge clk);
		kind_count[op.kind]++;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// Row near the page of the given row, so that fill spans often cut it.
	function automatic logic [7:0] near_page(input logic [7:0] row);
		int lo;
		lo = int'(row & 8'hF8) - 4 + int'($urandom_range(0, 16));
		if (lo < 0)
			lo = 0;
		if (lo > 255)
			lo = 255;
		return 8'(lo);
	endfunction

	initial begin
		pfbw_in_t   op;
		logic [7:0] column;
		logic [7:0] row;
		logic [1:0] kind;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: corners, chip boundary, every operation, fill span
		// edges, ignored positions and the unused operation code.
		send_op(make_op(KIND_DOT, 8'd0, 8'd0, 1'b1, 8'h00, 8'h00, 8'h00));
		send_op(make_op(KIND_DOT, 8'd127, 8'd63, 1'b1, 8'hFF, 8'hFF, 8'hFF));
		send_op(make_op(KIND_DOT, 8'd127, 8'd62, 1'b1, 8'h00, 8'h00, 8'h00));
		send_op(make_op(KIND_DOT, 8'd127, 8'd63, 1'b0, 8'h00, 8'h00, 8'h00));
		send_op(make_op(KIND_DOT, 8'd63, 8'd7, 1'b1, 8'h00, 8'h00, 8'h00));
		send_op(make_op(KIND_DOT, 8'd64, 8'd7, 1'b1, 8'h00, 8'h00, 8'h00));
		send_op(make_op(KIND_BYTE, 8'd63, 8'd56, 1'b0, 8'hFF, 8'h00, 8'h00));
		send_op(make_op(KIND_BYTE, 8'd64, 8'd8, 1'b1, 8'hA5, 8'hFF, 8'hFF));
		send_op(make_op(KIND_BYTE, 8'd63, 8'd56, 1'b0, 8'h00, 8'h00, 8'h00));
		send_op(make_op(KIND_FILL, 8'd10, 8'd20, 1'b1, 8'h00, 8'd18, 8'd22));
		send_op(make_op(KIND_FILL, 8'd10, 8'd20, 1'b1, 8'h00, 8'd0, 8'd255));
		send_op(make_op(KIND_FILL, 8'd10, 8'd23, 1'b0, 8'h00, 8'd17, 8'd20));
		send_op(make_op(KIND_FILL, 8'd10, 8'd20, 1'b0, 8'h00, 8'd22, 8'd18));
		send_op(make_op(KIND_FILL, 8'd10, 8'd20, 1'b1, 8'h00, 8'd19, 8'd19));
		send_op(make_op(KIND_FILL, 8'd11, 8'd3, 1'b1, 8'h00, 8'd40, 8'd50));
		send_op(make_op(KIND_FILL, 8'd100, 8'd60, 1'b1, 8'h00, 8'd58, 8'd200));
		send_op(make_op(KIND_DOT, 8'd128, 8'd0, 1'b1, 8'h00, 8'h00, 8'h00));
		send_op(make_op(KIND_BYTE, 8'd255, 8'd10, 1'b1, 8'hFF, 8'h00, 8'h00));
		send_op(make_op(KIND_FILL, 8'd5, 8'd64, 1'b1, 8'h00, 8'd0, 8'd255));
		send_op(make_op(KIND_DOT, 8'd5, 8'd255, 1'b1, 8'h00, 8'h00, 8'h00));
		send_op(make_op(KIND_UNUSED, 8'd5, 8'd5, 1'b1, 8'hFF, 8'd0, 8'd255));
		send_op(make_op(KIND_DOT, 8'd40, 8'd33, 1'b1, 8'h00, 8'h00, 8'h00));
		send_op(make_op(KIND_DOT, 8'd40, 8'd34, 1'b1, 8'h00, 8'h00, 8'h00));
		send_op(make_op(KIND_FILL, 8'd40, 8'd39, 1'b0, 8'h00, 8'd32, 8'd34));

		// Random part: mostly in-range words, often hitting the byte just
		// written, with a share of ignored positions and unused codes.
		column = 8'd0;
		row    = 8'd0;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n == RANDOM_OPS - CALM_OPS)
				calm <= 1'b1;
			if ($urandom_range(0, 99) >= 30 || n == 0) begin
				column = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 127))
					: 8'($urandom_range(128, 255));
				row = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 63))
					: 8'($urandom_range(64, 255));
			end else if ($urandom_range(0, 1) == 0) begin
				row = {row[7:3], 3'($urandom())};
			end
			kind = ($urandom_range(0, 99) < 5) ? KIND_UNUSED : 2'($urandom_range(0, 2));
			op = make_op(kind, column, row, 1'($urandom()), 8'($urandom()),
				8'($urandom()), 8'($urandom()));
			if ($urandom_range(0, 99) < 70) begin
				op.rect_top = near_page(row);
				op.rect_end = near_page(row);
			end
			send_op(op);
		end
		in_valid <= 1'b0;

		// Drain: wait for every pending write, then keep watching the output so that
		// any extra output word is still caught.
		while (pending_writes != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Drove %0d dot, %0d byte, %0d fill and %0d unused-code words.",
			kind_count[KIND_DOT], kind_count[KIND_BYTE], kind_count[KIND_FILL],
			kind_count[KIND_UNUSED]);
		$display("Checked %0d controller writes; %0d words were ignored.",
			checked_writes, ignored_ops);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
